@@ src/percent_codec_stream_top_macros.svh @@
// Assertion macros used by the percent codec stream RTL.
`ifndef PERCENT_CODEC_STREAM_TOP_MACROS_SVH
`define PERCENT_CODEC_STREAM_TOP_MACROS_SVH

`ifndef SYNTH
// Checks that the consequent holds whenever the antecedent holds.
`define PCS_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("pcs assertion failed");
// Checks that the consequent holds in the cycle after the antecedent.
`define PCS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("pcs assertion failed");
`else
`define PCS_ASSERT_IMPLY(label, ante, cons)
`define PCS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

@@ src/pcs_pkg.sv @@
// Package with beat types, character codes and conversion functions of the percent codec.
`timescale 1ns / 1ps

package pcs_pkg;

	// Character codes.
	localparam logic [7:0] CH_PCT   = 8'h25;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;

	// Direction register values; the core resets to DIR_DECODE.
	localparam logic DIR_ENCODE = 1'b0;
	localparam logic DIR_DECODE = 1'b1;

	// Decode phase codes.
	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_PCT   = 2'd1;
	localparam logic [1:0] PH_DIGIT = 2'd2;

	// Most result beats one input beat can cause.
	localparam int RUN_MAX = 3;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       string_end;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_last;
		logic       out_string_end;
	} out_beat_t;

	// One run of result bytes handed to the output stage.
	typedef struct packed {
		logic                      valid;
		logic [1:0]                count;
		logic [RUN_MAX-1:0][7:0]   bytes;
		logic                      str_end;
	} run_t;

	// Result of converting one input beat.
	typedef struct packed {
		logic [1:0]                count;
		logic [RUN_MAX-1:0][7:0]   bytes;
		logic [1:0]                next_phase;
		logic [7:0]                next_held;
	} conv_t;

	function automatic logic is_hex(logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
			(c >= 8'h61 && c <= 8'h66);
	endfunction

	// Value of a hex digit; only the low nibble of the letter offset matters.
	function automatic logic [3:0] hex_val(logic [7:0] c);
		logic [3:0] v;
		if (c <= 8'h39) begin
			v = c[3:0];
		end else begin
			v = c[3:0] + 4'd9;
		end
		return v;
	endfunction

	function automatic logic [7:0] hex_upper(logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'd0, v};
		end else begin
			r = 8'h37 + {4'd0, v};
		end
		return r;
	endfunction

	// Converts one input beat given the direction and the held escape.
	function automatic conv_t convert(logic dir, logic [1:0] phase, logic [7:0] held,
		in_beat_t b);
		conv_t r;
		logic  fresh;
		logic  last;
		r            = '0;
		fresh        = 1'b0;
		last         = b.string_end;
		r.next_phase = PH_IDLE;
		r.next_held  = held;
		if (dir == DIR_ENCODE) begin
			if (b.in_byte == CH_SPACE || b.in_byte == CH_AMP ||
				b.in_byte == CH_QUEST || b.in_byte == CH_HASH) begin
				r.bytes[0] = CH_PCT;
				r.bytes[1] = hex_upper(b.in_byte[7:4]);
				r.bytes[2] = hex_upper(b.in_byte[3:0]);
				r.count    = 2'd3;
			end else begin
				r.bytes[0] = b.in_byte;
				r.count    = 2'd1;
			end
		end else begin
			case (phase)
				PH_PCT: begin
					if (is_hex(b.in_byte)) begin
						if (last) begin
							r.bytes[0] = CH_PCT;
							r.bytes[1] = b.in_byte;
							r.count    = 2'd2;
						end else begin
							r.next_held  = b.in_byte;
							r.next_phase = PH_DIGIT;
						end
					end else begin
						r.bytes[0] = CH_PCT;
						r.count    = 2'd1;
						fresh      = 1'b1;
					end
				end
				PH_DIGIT: begin
					r.next_held = 8'd0;
					if (is_hex(b.in_byte)) begin
						r.bytes[0] = {hex_val(held), hex_val(b.in_byte)};
						r.count    = 2'd1;
					end else begin
						r.bytes[0] = CH_PCT;
						r.bytes[1] = held;
						r.count    = 2'd2;
						fresh      = 1'b1;
					end
				end
				default: begin
					fresh = 1'b1;
				end
			endcase
			// A byte seen as new input either opens an escape or passes through.
			if (fresh) begin
				if (b.in_byte == CH_PCT && !last) begin
					r.next_phase = PH_PCT;
				end else begin
					r.bytes[r.count] = b.in_byte;
					r.count          = r.count + 2'd1;
				end
			end
		end
		if (last) begin
			r.next_phase = PH_IDLE;
			r.next_held  = 8'd0;
		end
		return r;
	endfunction

endpackage

@@ src/pcs_core.sv @@
// Input register, escape state and per-beat conversion of the percent codec.
`timescale 1ns / 1ps

module pcs_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  pcs_pkg::in_beat_t in_beat,
	input  logic             cfg_we,
	input  logic             cfg_wdata,
	input  logic             can_load,
	output pcs_pkg::run_t    run
);
	import pcs_pkg::*;

	logic       valid_s1;
	in_beat_t   beat_s1;
	logic       dir_q;
	logic [1:0] phase_q;
	logic [7:0] held_q;
	conv_t      conv;
	logic       load;

	// Conversion of the registered beat against the held escape.
	always_comb begin
		conv = convert(dir_q, phase_q, held_q, beat_s1);
	end

	assign load     = valid_s1 && can_load;
	assign in_stall = valid_s1 && !can_load;

	always_comb begin
		run.valid   = valid_s1;
		run.count   = conv.count;
		run.bytes   = conv.bytes;
		run.str_end = beat_s1.string_end;
	end

	// Input register: refills in the same cycle it hands its beat on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (load) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			beat_s1 <= in_beat;
		end
	end

	// Direction and escape state; a register write drops anything held.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q   <= DIR_DECODE;
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (cfg_we) begin
			dir_q   <= cfg_wdata;
			phase_q <= PH_IDLE;
			held_q  <= 8'd0;
		end else if (load) begin
			phase_q <= conv.next_phase;
			held_q  <= conv.next_held;
		end
	end

endmodule

@@ src/pcs_out.sv @@
// Result register that sends the run of one input beat out one byte per beat.
`timescale 1ns / 1ps
`include "percent_codec_stream_top_macros.svh"

module pcs_out (
	input  logic              clk,
	input  logic              arst_n,
	input  pcs_pkg::run_t     run,
	output logic              can_load,
	output logic              out_valid,
	input  logic              out_stall,
	output pcs_pkg::out_beat_t out_beat
);
	import pcs_pkg::*;

	logic [1:0]              count_q;
	logic [1:0]              idx_q;
	logic [RUN_MAX-1:0][7:0] bytes_q;
	logic                    str_end_q;
	logic                    take;
	logic                    last_beat;
	logic                    done;
	logic                    load;

	assign out_valid = (count_q != 2'd0);
	assign take      = out_valid && !out_stall;
	assign last_beat = (idx_q == count_q - 2'd1);
	assign done      = take && last_beat;
	assign can_load  = !out_valid || done;
	assign load      = run.valid && can_load;

	always_comb begin
		out_beat.out_byte       = bytes_q[idx_q];
		out_beat.run_last       = last_beat;
		out_beat.out_string_end = last_beat && str_end_q;
	end

	// Run counters: a new run loads as soon as the old one is drained.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
			idx_q   <= 2'd0;
		end else if (load) begin
			count_q <= run.count;
			idx_q   <= 2'd0;
		end else if (done) begin
			count_q <= 2'd0;
			idx_q   <= 2'd0;
		end else if (take) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			bytes_q   <= run.bytes;
			str_end_q <= run.str_end;
		end
	end

	// The byte index stays inside the run.
	`PCS_ASSERT_IMPLY(a_idx_in_run, out_valid, idx_q < count_q)
	// A drained run with nothing waiting leaves the output empty.
	`PCS_ASSERT_NEXT(a_drain_empty, done && !run.valid, !out_valid)
	// A beat taken in the middle of a run moves to the next byte.
	`PCS_ASSERT_NEXT(a_idx_step, take && !last_beat, idx_q == $past(idx_q) + 2'd1)
	// The end of a string always closes a run.
	`PCS_ASSERT_IMPLY(a_end_closes, out_valid && out_beat.out_string_end, out_beat.run_last)

endmodule

@@ src/percent_codec_stream_top.sv @@
// Top level of the streaming URL percent encoder and decoder.
// Usage:
//   The input channel (in_valid, in_stall, in_beat) moves one string byte per beat,
//   with string_end set on the last byte of a string. The output channel
//   (out_valid, out_stall, out_beat) moves one converted byte per beat; run_last
//   marks the last byte caused by one input beat, out_string_end the last byte
//   of a string. cfg_we with cfg_wdata writes the direction: 0 encodes, 1 decodes.
//   Write it only while no beat is in flight; a write drops any held escape.
// Timing:
//   An accepted input beat waits in the input register, is converted there
//   combinationally and loads into the result register, where its first output byte can be taken.
//   One input beat is taken per cycle while each causes at most one byte and
//   out_stall stays low; an encoded escape sends three bytes, one per cycle
//   through the result register, so the input stalls behind it. Beats that only
//   extend a held escape produce nothing.
// Reset:
//   arst_n empties both registers, clears the escape state and sets decode mode.
// Stall:
//   While out_stall is high the output byte holds; once the input register is
//   also full, in_stall rises until the run ahead drains.
`timescale 1ns / 1ps

module percent_codec_stream_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  pcs_pkg::in_beat_t  in_beat,
	output logic               out_valid,
	input  logic               out_stall,
	output pcs_pkg::out_beat_t out_beat,
	input  logic               cfg_we,
	input  logic               cfg_wdata
);
	import pcs_pkg::*;

	run_t run;
	logic can_load;

	// Input register and conversion.
	pcs_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_beat  (in_beat),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.can_load (can_load),
		.run      (run)
	);

	// Result register and byte sequencing.
	pcs_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.run      (run),
		.can_load (can_load),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_beat (out_beat)
	);

endmodule

@@ tb/percent_codec_stream_top_tb.sv @@
// Self-checking testbench for the streaming URL percent encoder and decoder.
`timescale 1ns / 1ps

module percent_codec_stream_top_tb;

	import pcs_pkg::*;

	localparam int SETTLE_CYCLES = 6;
	localparam int DRAIN_CYCLES  = 10;
	localparam int IDLE_LIMIT    = 2000;

	typedef logic [7:0] byte_q_t[$];

	// Expected-byte store plus a private copy of the codec state.
	class byte_scoreboard;
		logic            dir;
		logic [1:0]      esc_state;
		logic [7:0]      esc_digit;
		out_beat_t       expected_q[$];
		int              errors;
		int              in_count;
		int              out_count;

		function new();
			dir       = DIR_DECODE;
			esc_state = PH_IDLE;
			esc_digit = 8'd0;
			errors    = 0;
			in_count  = 0;
			out_count = 0;
		endfunction

		// Any direction write drops a partly received escape.
		function void set_direction(logic d);
			dir       = d;
			esc_state = PH_IDLE;
			esc_digit = 8'd0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		// Returns the digit value, or -1 for a byte that is not a hex digit.
		function int digit_value(logic [7:0] c);
			if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
			if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
			if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
			return -1;
		endfunction

		function logic [7:0] nibble_char(logic [3:0] v);
			return (v < 4'd10) ? 8'h30 + 8'(v) : 8'h37 + 8'(v);
		endfunction

		// Works out the result beats of one accepted input beat.
		function void note_input(in_beat_t b);
			logic [7:0] run[$];
			logic       last;
			logic       reprocess;
			int         hi;
			int         lo;
			out_beat_t  beat;
			last      = b.string_end;
			reprocess = 1'b0;
			in_count++;
			if (dir == DIR_ENCODE) begin
				if (b.in_byte == CH_SPACE || b.in_byte == CH_AMP ||
					b.in_byte == CH_QUEST || b.in_byte == CH_HASH) begin
					run.push_back(CH_PCT);
					run.push_back(nibble_char(b.in_byte[7:4]));
					run.push_back(nibble_char(b.in_byte[3:0]));
				end else begin
					run.push_back(b.in_byte);
				end
			end else begin
				case (esc_state)
					PH_PCT: begin
						if (digit_value(b.in_byte) >= 0) begin
							if (last) begin
								run.push_back(CH_PCT);
								run.push_back(b.in_byte);
								esc_state = PH_IDLE;
							end else begin
								esc_digit = b.in_byte;
								esc_state = PH_DIGIT;
							end
						end else begin
							run.push_back(CH_PCT);
							esc_state = PH_IDLE;
							reprocess = 1'b1;
						end
					end
					PH_DIGIT: begin
						esc_state = PH_IDLE;
						lo        = digit_value(b.in_byte);
						if (lo >= 0) begin
							hi = digit_value(esc_digit);
							if (hi < 0) hi = 0;
							run.push_back({hi[3:0], lo[3:0]});
						end else begin
							run.push_back(CH_PCT);
							run.push_back(esc_digit);
							reprocess = 1'b1;
						end
						esc_digit = 8'd0;
					end
					default: begin
						esc_state = PH_IDLE;
						reprocess = 1'b1;
					end
				endcase
				// A byte taken as new input either opens an escape or passes through.
				if (reprocess) begin
					if (b.in_byte == CH_PCT && !last) begin
						esc_state = PH_PCT;
					end else begin
						run.push_back(b.in_byte);
					end
				end
			end
			if (last) begin
				esc_state = PH_IDLE;
				esc_digit = 8'd0;
			end
			foreach (run[i]) begin
				beat.out_byte       = run[i];
				beat.run_last       = (i == run.size() - 1);
				beat.out_string_end = last && (i == run.size() - 1);
				expected_q.push_back(beat);
			end
		endfunction

		// Compares one accepted output beat with the oldest expected one.
		function void check_result(out_beat_t got);
			out_beat_t want;
			out_count++;
			if (expected_q.size() == 0) begin
				$error("unexpected output beat: out_byte %02h", got.out_byte);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.out_byte !== want.out_byte) begin
				$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
				errors++;
			end
			if (got.run_last !== want.run_last) begin
				$error("run_last: expected %0b, actual %0b", want.run_last, got.run_last);
				errors++;
			end
			if (got.out_string_end !== want.out_string_end) begin
				$error("out_string_end: expected %0b, actual %0b", want.out_string_end,
					got.out_string_end);
				errors++;
			end
		endfunction
	endclass

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_stall;
	in_beat_t  in_beat   = '0;
	logic      out_valid;
	logic      out_stall = 1'b0;
	out_beat_t out_beat;
	logic      cfg_we    = 1'b0;
	logic      cfg_wdata = 1'b0;

	byte_scoreboard sb = new();

	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   items_sent    = 0;
	int   idle_cycles   = 0;
	logic cur_dir       = DIR_DECODE;

	percent_codec_stream_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_beat   (in_beat),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_beat  (out_beat),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Random back-pressure on the output side.
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// Beat monitor and watchdog on stretches with no handshake.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				sb.note_input(in_beat);
			end
			if (out_valid && !out_stall) begin
				sb.check_result(out_beat);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("timeout: no beat moved for %0d cycles", IDLE_LIMIT);
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	// Presents one beat after a random gap and holds it until accepted.
	task automatic send_beat(input in_beat_t b);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_beat  <= b;
		do @(posedge clk); while (in_stall);
		items_sent++;
	endtask

	// Sends a string, marking its last byte as the end.
	task automatic send_bytes(input byte_q_t s);
		in_beat_t b;
		foreach (s[i]) begin
			b.in_byte    = s[i];
			b.string_end = (i == s.size() - 1);
			send_beat(b);
		end
	endtask

	// Stops sending and waits for every expected byte, then for the pipeline.
	// The first edge lets the monitor note the last accepted beat.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(input logic d);
		wait_drained();
		sb.set_direction(d);
		cur_dir   = d;
		cfg_we    <= 1'b1;
		cfg_wdata <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [7:0] random_hex_char();
		int v;
		v = $urandom_range(15);
		if (v < 10) return 8'h30 + 8'(v);
		if ($urandom_range(1)) return 8'h41 + 8'(v - 10);
		return 8'h61 + 8'(v - 10);
	endfunction

	function automatic logic [7:0] random_reserved();
		case ($urandom_range(3))
			0: return CH_SPACE;
			1: return CH_AMP;
			2: return CH_QUEST;
			default: return CH_HASH;
		endcase
	endfunction

	// Builds a random string: mostly well-formed escapes when decoding,
	// a mix of reserved characters and arbitrary bytes when encoding.
	task automatic send_random_string(input int max_len);
		byte_q_t s;
		int      n;
		int      k;
		n = $urandom_range(max_len, 1);
		while (s.size() < n) begin
			k = $urandom_range(99);
			if (cur_dir == DIR_ENCODE) begin
				s.push_back(k < 40 ? random_reserved() : 8'($urandom_range(255)));
			end else if (k < 50) begin
				s.push_back(CH_PCT);
				s.push_back(random_hex_char());
				s.push_back(random_hex_char());
			end else if (k < 65) begin
				s.push_back(CH_PCT);
				s.push_back(k < 58 ? random_hex_char() : 8'($urandom_range(255)));
			end else if (k < 72) begin
				s.push_back(CH_PCT);
			end else begin
				s.push_back(8'($urandom_range(255)));
			end
		end
		send_bytes(s);
	endtask

	task automatic send_random_items(input int count);
		int stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at) send_random_string(8);
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed decode checks in the reset direction.
		send_bytes('{CH_PCT, CH_PCT, 8'h36, 8'h66});     // double percent, lower case
		send_bytes('{CH_PCT, 8'h30, 8'h30});             // decoded zero byte at end
		send_bytes('{CH_PCT, 8'h47});                    // percent then non-hex
		send_bytes('{CH_PCT, 8'h34, 8'h5A});             // one digit then non-hex
		send_bytes('{CH_PCT});                           // lone percent at end
		send_bytes('{CH_PCT, 8'h33});                    // percent and digit at end
		send_bytes('{8'hFF});
		send_bytes('{CH_PCT, 8'h41});                    // percent and letter digit at end
		wait_drained();

		// Directed encode checks.
		write_direction(DIR_ENCODE);
		send_bytes('{CH_SPACE, CH_AMP, CH_QUEST, CH_HASH, 8'h00, 8'hFF});

		// Random phase: sender idles less than the receiver.
		send_idle_pct = 25;
		recv_idle_pct = 46;
		send_random_items(15);
		write_direction(DIR_DECODE);
		send_random_items(25);

		// Random phase: receiver idles less, with a full drain before each batch.
		send_idle_pct = 46;
		recv_idle_pct = 25;
		write_direction(DIR_DECODE);
		send_random_items(15);
		wait_drained();
		send_random_items(15);
		write_direction(DIR_ENCODE);
		send_random_items(12);

		// Random phase with no idling on either side.
		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_items(12);
		write_direction(DIR_DECODE);
		send_random_items(20);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Run covered %0d input beats and %0d output beats in both directions,",
			sb.in_count, sb.out_count);
		$display("with escapes, broken escapes and random stalls on both channels.");
		if (sb.errors == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
